// ----- sv/pfq_pkg.sv -----
`default_nettype none
package pfq_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_POINT,
    ST_POW,
    ST_ACC,
    ST_END_LO,
    ST_END_UP,
    ST_FINAL,
    ST_OUT
  } state_t;

  localparam logic METHOD_RIEMANN = 1'b0;
  localparam logic METHOD_SIMPSON = 1'b1;

  localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

  // signed saturating add, flags clamp
  function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = {1'b1, (s[64] ? SAT_MIN : SAT_MAX)};
    end else begin
      sat_add = {1'b0, s[63:0]};
    end
  endfunction

endpackage
`default_nettype wire

// ----- sv/pfq_if.sv -----
`default_nettype none
interface pfq_in_if;
  logic              valid;
  logic              ready;
  logic              method;
  logic [3:0]        exponent;
  logic signed [5:0] lower_limit;
  logic signed [5:0] upper_limit;
  logic [20:0]       step_count;
  modport source (output valid, method, exponent, lower_limit, upper_limit, step_count,
                  input ready);
  modport sink (input valid, method, exponent, lower_limit, upper_limit, step_count,
                output ready);
endinterface

interface pfq_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] integral;
  logic               overflow;
  modport source (output valid, integral, overflow, input ready);
  modport sink (input valid, integral, overflow, output ready);
endinterface
`default_nettype wire

// ----- sv/pfq_mul.sv -----
`default_nettype none
// sequential fixed-point multiply: four 32x32 partial products, one per cycle,
// done pulses once the four are summed, truncated toward zero and saturated
module pfq_mul #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  output logic                    done,
  output logic signed [63:0]      prod,
  output logic                    sat
);
  logic [63:0]  xm_r, ym_r;
  logic         neg_r;
  logic [127:0] acc_r;
  logic [2:0]   cnt_r;
  logic         busy_r;
  logic [63:0]  part_r;
  logic [1:0]   sel_r;
  logic         pend_r;
  logic         done_r;

  logic [31:0]  xa, yb;
  logic [63:0]  pp;
  logic [127:0] sh;
  logic [127:0] fin;
  logic [63:0]  mag;
  logic         big;

  // partial product selection
  always_comb begin
    xa = sel_r[0] ? xm_r[63:32] : xm_r[31:0];
    yb = sel_r[1] ? ym_r[63:32] : ym_r[31:0];
    pp = {32'd0, xa} * {32'd0, yb};
  end

  // shift of registered partial product into place
  always_comb begin
    sh = {64'd0, part_r};
    case (cnt_r)
      3'd2: sh = {32'd0, part_r, 32'd0};
      3'd3: sh = {32'd0, part_r, 32'd0};
      3'd4: sh = {part_r, 64'd0};
      default: sh = {64'd0, part_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
      sel_r  <= 2'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      pend_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
      sel_r  <= 2'd0;
      neg_r  <= a[63] ^ b[63];
      xm_r   <= a[63] ? (64'd0 - a) : a;
      ym_r   <= b[63] ? (64'd0 - b) : b;
      acc_r  <= 128'd0;
    end else if (busy_r) begin
      part_r <= pp;
      pend_r <= (cnt_r < 3'd4);
      if (pend_r) acc_r <= acc_r + sh;
      cnt_r  <= cnt_r + 3'd1;
      sel_r  <= sel_r + 2'd1;
      done_r <= (cnt_r == 3'd4);
      if (cnt_r == 3'd4) busy_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
    end
  end

  // final truncation and saturation
  always_comb begin
    fin  = acc_r >> FRAC_BITS;
    big  = |fin[127:64];
    mag  = fin[63:0];
    sat  = 1'b0;
    if (big) begin
      sat  = 1'b1;
      prod = neg_r ? pfq_pkg::SAT_MIN : pfq_pkg::SAT_MAX;
    end else if (neg_r) begin
      if (mag > 64'h8000_0000_0000_0000) begin
        sat  = 1'b1;
        prod = pfq_pkg::SAT_MIN;
      end else begin
        prod = 64'd0 - mag;
      end
    end else if (mag[63]) begin
      sat  = 1'b1;
      prod = pfq_pkg::SAT_MAX;
    end else begin
      prod = mag;
    end
  end

  assign done = done_r;
endmodule
`default_nettype wire

// ----- sv/pfq_div.sv -----
`default_nettype none
// restoring divider, one quotient bit per cycle, truncated toward zero
module pfq_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] num,
  input  wire logic [23:0]        den,
  output logic                    done,
  output logic signed [63:0]      quo
);
  logic [63:0] q_r;
  logic [24:0] rem_r;
  logic [23:0] d_r;
  logic        neg_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [24:0] trial;
  logic [24:0] shifted;

  always_comb begin
    shifted = {rem_r[23:0], q_r[63]};
    trial   = shifted - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
      neg_r  <= num[63];
      q_r    <= num[63] ? (64'd0 - num) : num;
      rem_r  <= 25'd0;
      d_r    <= den;
    end else if (busy_r) begin
      if (!trial[24]) begin
        rem_r <= trial;
        q_r   <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= shifted;
        q_r   <= {q_r[62:0], 1'b0};
      end
      cnt_r  <= cnt_r + 7'd1;
      done_r <= (cnt_r == 7'd63);
      if (cnt_r == 7'd63) busy_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? (64'd0 - q_r) : q_r;
endmodule
`default_nettype wire

// ----- sv/power_function_quadrature_top.sv -----
`default_nettype none
// Integral of x^k between integer limits, Q47.16 result, saturated.
// in_*: one request (method, exponent, lower_limit, upper_limit, step_count)
// transfers when in_valid and in_ready are high. out_*: one result
// (integral, overflow) per request, held until out_ready.
// Powers and their products with the step go through one shared multiplier
// (start, four 32x32 partial products, accumulate, done); the step width comes
// first from a restoring division, and the step over three from its own multiply.
// in_ready is low from request transfer until the result transfers, so one
// request is in flight at a time and a stalled receiver simply holds the block.
// Synchronous reset returns the sequencer to idle and drops out_valid; nothing
// else is kept between items.
module power_function_quadrature_top #(
  parameter int MAX_STEPS    = 1048576,
  parameter int MAX_EXPONENT = 8,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pfq_in_if.sink    in_ch,
  pfq_out_if.source out_ch
);
  localparam int NW = $clog2(MAX_STEPS + 1);
  localparam int KW = $clog2(MAX_EXPONENT + 1);
  // reciprocal of 3 scaled by 2^33, exact for step magnitudes below 2^31
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  pfq_pkg::state_t state_r, state_nxt;

  logic               method_r;
  logic [KW-1:0]      k_r, kcnt_r;
  logic [NW-1:0]      n_r, i_r;
  logic signed [63:0] loq_r, upq_r, h_r, x_r, pw_r, acc_r, res_r;
  logic signed [63:0] lok_r, h3_r;
  logic               ovf_r;

  logic               mul_start, mul_done, mul_sat;
  logic signed [63:0] mul_a, mul_b, mul_p;
  logic               div_start, div_done;
  logic signed [63:0] div_q;
  logic [23:0]        div_den;
  logic signed [63:0] div_num;
  logic               div_go_r;

  logic [4:0]         kin;
  logic [20:0]        nin;
  logic               mul_busy_r;
  logic [64:0]        sa1, sa2, sa3;
  logic [64:0]        sb1, sb2;

  logic [30:0]        h3_mag;
  logic [62:0]        h3_prod;
  logic [63:0]        h3_q;
  logic signed [63:0] h3_c;

  pfq_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p), .sat(mul_sat)
  );

  pfq_div u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  // clamp of request fields
  always_comb begin
    kin = {1'b0, in_ch.exponent};
    if (kin == 5'd0) kin = 5'd1;
    if (kin > 5'(MAX_EXPONENT)) kin = 5'(MAX_EXPONENT);
    nin = in_ch.step_count;
    if (nin == 21'd0) nin = 21'd1;
    if (32'(nin) > 32'(MAX_STEPS)) nin = 21'(MAX_STEPS);
  end

  assign in_ch.ready     = (state_r == pfq_pkg::ST_IDLE);
  assign out_ch.valid    = (state_r == pfq_pkg::ST_OUT);
  assign out_ch.integral = res_r;
  assign out_ch.overflow = ovf_r;

  assign div_num   = upq_r - loq_r;
  assign div_den   = 24'(n_r);
  assign div_start = div_go_r;

  // step over three, truncated toward zero
  always_comb begin
    h3_mag  = h_r[63] ? 31'(64'd0 - h_r) : h_r[30:0];
    h3_prod = {32'd0, h3_mag} * {31'd0, RECIP3};
    h3_q    = {34'd0, h3_prod[62:33]};
    h3_c    = h_r[63] ? -$signed(h3_q) : $signed(h3_q);
  end

  // accumulate: weighted power or riemann product into sum
  always_comb begin
    sa1 = pfq_pkg::sat_add(pw_r, pw_r);
    sa2 = pfq_pkg::sat_add(sa1[63:0], sa1[63:0]);
    if (method_r == pfq_pkg::METHOD_RIEMANN) begin
      sa3 = pfq_pkg::sat_add(acc_r, mul_p);
    end else if (i_r[0]) begin
      sa3 = pfq_pkg::sat_add(acc_r, sa2[63:0]);
      sa3[64] = sa3[64] | sa1[64] | sa2[64];
    end else begin
      sa3 = pfq_pkg::sat_add(acc_r, sa1[63:0]);
      sa3[64] = sa3[64] | sa1[64];
    end
  end

  // simpson total: end points first, then the inner sum
  always_comb begin
    sb1 = pfq_pkg::sat_add(lok_r, pw_r);
    sb2 = pfq_pkg::sat_add(sb1[63:0], acc_r);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    mul_a     = pw_r;
    mul_b     = x_r;
    unique case (state_r)
      pfq_pkg::ST_IDLE: if (in_ch.valid) state_nxt = pfq_pkg::ST_DIV;
      pfq_pkg::ST_DIV: begin
        if (div_done) begin
          // simpson with a single step has no inner points
          if (32'(i_r) >= 32'(n_r)) state_nxt = pfq_pkg::ST_END_LO;
          else                      state_nxt = pfq_pkg::ST_POINT;
        end
      end
      pfq_pkg::ST_POINT: state_nxt = pfq_pkg::ST_POW;
      pfq_pkg::ST_POW: begin
        if (!mul_busy_r) begin
          if (kcnt_r < k_r) begin
            mul_start = 1'b1;
          end else if (method_r == pfq_pkg::METHOD_RIEMANN) begin
            mul_start = 1'b1;
            mul_b     = h_r;
            state_nxt = pfq_pkg::ST_ACC;
          end else begin
            state_nxt = pfq_pkg::ST_ACC;
          end
        end
      end
      pfq_pkg::ST_ACC: begin
        if (method_r == pfq_pkg::METHOD_SIMPSON || mul_done) begin
          if (32'(i_r) + 32'd1 >= 32'(n_r)) begin
            state_nxt = (method_r == pfq_pkg::METHOD_SIMPSON) ?
                        pfq_pkg::ST_END_LO : pfq_pkg::ST_OUT;
          end else begin
            state_nxt = pfq_pkg::ST_POINT;
          end
        end
      end
      pfq_pkg::ST_END_LO: begin
        if (!mul_busy_r) begin
          if (kcnt_r >= k_r) begin
            state_nxt = pfq_pkg::ST_END_UP;
          end else begin
            mul_start = 1'b1;
            mul_b     = loq_r;
          end
        end
      end
      pfq_pkg::ST_END_UP: begin
        if (!mul_busy_r) begin
          mul_start = 1'b1;
          mul_b     = upq_r;
          if (kcnt_r >= k_r) begin
            mul_a     = h3_r;
            mul_b     = sb2[63:0];
            state_nxt = pfq_pkg::ST_FINAL;
          end
        end
      end
      pfq_pkg::ST_FINAL: if (mul_done) state_nxt = pfq_pkg::ST_OUT;
      pfq_pkg::ST_OUT: if (out_ch.ready) state_nxt = pfq_pkg::ST_IDLE;
      default: state_nxt = pfq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pfq_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // multiply-in-flight tracker
  always_ff @(posedge clk) begin
    if (!rst_n)         mul_busy_r <= 1'b0;
    else if (mul_start) mul_busy_r <= 1'b1;
    else if (mul_done)  mul_busy_r <= 1'b0;
  end

  // division starts the cycle after the request transfer
  always_ff @(posedge clk) begin
    if (!rst_n) div_go_r <= 1'b0;
    else        div_go_r <= (state_r == pfq_pkg::ST_IDLE) && in_ch.valid;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    h3_r <= h3_c;
    if (state_r == pfq_pkg::ST_IDLE && in_ch.valid) begin
      method_r <= in_ch.method;
      k_r      <= KW'(kin);
      n_r      <= NW'(nin);
      loq_r    <= 64'(in_ch.lower_limit) <<< FRAC_BITS;
      upq_r    <= 64'(in_ch.upper_limit) <<< FRAC_BITS;
      acc_r    <= 64'sd0;
      ovf_r    <= 1'b0;
      i_r      <= NW'(in_ch.method);
    end
    if (div_done && state_r == pfq_pkg::ST_DIV) begin
      h_r <= div_q;
      if (method_r == pfq_pkg::METHOD_SIMPSON) x_r <= loq_r + div_q;
      else                                     x_r <= loq_r;
      pw_r   <= loq_r;
      kcnt_r <= KW'(1);
    end
    if (state_r == pfq_pkg::ST_POINT) begin
      pw_r   <= x_r;
      kcnt_r <= KW'(1);
    end
    if (mul_done && (state_r == pfq_pkg::ST_POW || state_r == pfq_pkg::ST_END_LO ||
                     state_r == pfq_pkg::ST_END_UP)) begin
      pw_r   <= mul_p;
      kcnt_r <= kcnt_r + KW'(1);
      ovf_r  <= ovf_r | mul_sat;
    end
    if (state_r == pfq_pkg::ST_ACC &&
        (method_r == pfq_pkg::METHOD_SIMPSON || mul_done)) begin
      acc_r <= sa3[63:0];
      ovf_r <= ovf_r | sa3[64] |
               ((method_r == pfq_pkg::METHOD_RIEMANN) & mul_sat);
      i_r   <= i_r + NW'(1);
      x_r   <= x_r + h_r;
      if (32'(i_r) + 32'd1 >= 32'(n_r)) begin
        pw_r   <= loq_r;
        kcnt_r <= KW'(1);
      end
    end
    if (state_r == pfq_pkg::ST_END_LO && !mul_busy_r && kcnt_r >= k_r) begin
      lok_r  <= pw_r;
      pw_r   <= upq_r;
      kcnt_r <= KW'(1);
    end
    if (state_r == pfq_pkg::ST_END_UP && !mul_busy_r && kcnt_r >= k_r) begin
      ovf_r <= ovf_r | sb1[64] | sb2[64];
    end
    if (state_r == pfq_pkg::ST_FINAL && mul_done) begin
      res_r <= mul_p;
      ovf_r <= ovf_r | mul_sat;
    end
    if (state_r == pfq_pkg::ST_ACC && method_r == pfq_pkg::METHOD_RIEMANN && mul_done &&
        32'(i_r) + 32'd1 >= 32'(n_r)) begin
      res_r <= sa3[63:0];
    end
  end
endmodule
`default_nettype wire

// ----- sv/pfq_checker.sv -----
`default_nettype none
module pfq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_integral,
  input wire logic        out_overflow
);
  // a request is never taken while a result waits
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while result pending");

  // a transfer in leaves the block busy
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready right after transfer");

  // a stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_integral) &&
                                   $stable(out_overflow)))
    else $error("result changed under stall");

  // the result goes away once taken
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> !out_valid) else $error("result repeated");
endmodule

bind power_function_quadrature_top pfq_checker u_pfq_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_integral(out_ch.integral), .out_overflow(out_ch.overflow)
);
`default_nettype wire
